/* rtl/fltp_pkg.sv */
// fltp_pkg: types and constants shared by the container tag parser.
// No dependencies.
package fltp_pkg;

    localparam logic [31:0] FILE_SIGNATURE = 32'h464C_5601;
    localparam logic [7:0]  FLAG_RSVD_MASK = 8'hFA;
    localparam logic [31:0] FILE_DATA_OFFS = 32'd9;
    localparam logic [24:0] TAG_HDR_LEN    = 25'd11;
    localparam logic [4:0]  TAG_AUDIO      = 5'd8;
    localparam logic [4:0]  TAG_VIDEO      = 5'd9;
    localparam logic [3:0]  CODEC_AAC      = 4'd10;
    localparam logic [3:0]  CODEC_AVC      = 4'd7;
    localparam logic [3:0]  FRAME_INFO     = 4'd5;
    localparam int          M_TDATA_W      = 144;

    typedef enum logic [4:0] {
        PH_FILE_HDR = 5'b00001,
        PH_TAG_HDR  = 5'b00010,
        PH_PAYLOAD  = 5'b00100,
        PH_TRAILER  = 5'b01000,
        PH_ERROR    = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        ST_TAG         = 2'd0,
        ST_HEADER_OK   = 2'd1,
        ST_HEADER_BAD  = 2'd2,
        ST_TRAILER_BAD = 2'd3
    } t_status;

    typedef struct packed {
        t_phase      phase;
        logic [23:0] pos;
        logic [31:0] asm_word;
        logic [7:0]  hdr_byte;
        logic [23:0] size;
        logic [31:0] stamp;
        logic [23:0] stream;
        logic [7:0]  media;
        logic [7:0]  packet;
        logic [23:0] comp;
        logic [7:0]  cmd;
        logic [2:0]  extras;
    } t_state;

    typedef struct packed {
        logic    emit;
        t_status status;
    } t_emit;

endpackage

/* rtl/fltp_step.sv */
// fltp_step: per-byte next-state logic of the tag parser.
// Depends on fltp_pkg.
module fltp_step (
    input  fltp_pkg::t_state i_state,
    input  logic [7:0]       i_byte,
    output fltp_pkg::t_state o_state,
    output fltp_pkg::t_emit  o_emit
);

    logic [23:0] w_pos_inc;
    logic [24:0] w_trl_expect;
    logic [31:0] w_asm_shift;
    logic        w_avc;
    logic [23:0] w_cmd_pos;
    logic        w_hdr_bad;

    assign w_pos_inc    = i_state.pos + 24'd1;
    assign w_trl_expect = {1'b0, i_state.size} + fltp_pkg::TAG_HDR_LEN;
    assign w_asm_shift  = {i_state.asm_word[23:0], i_byte};
    assign w_avc        = (i_state.media[3:0] == fltp_pkg::CODEC_AVC);
    assign w_cmd_pos    = w_avc ? 24'd5 : 24'd1;

    always_comb begin
        w_hdr_bad = 1'b0;
        if (i_state.pos == 24'd3 && w_asm_shift != fltp_pkg::FILE_SIGNATURE) begin
            w_hdr_bad = 1'b1;
        end else if (i_state.pos == 24'd4 && (i_byte & fltp_pkg::FLAG_RSVD_MASK) != 8'd0) begin
            w_hdr_bad = 1'b1;
        end else if (i_state.pos == 24'd8 && w_asm_shift != fltp_pkg::FILE_DATA_OFFS) begin
            w_hdr_bad = 1'b1;
        end else if (i_state.pos >= 24'd12 && w_asm_shift != 32'd0) begin
            w_hdr_bad = 1'b1;
        end
    end

    always_comb begin
        o_state        = i_state;
        o_emit.emit    = 1'b0;
        o_emit.status  = fltp_pkg::ST_TAG;
        unique case (i_state.phase)
            fltp_pkg::PH_FILE_HDR: begin
                o_state.asm_word = w_asm_shift;
                if (i_state.pos == 24'd4) begin
                    o_state.media = i_byte;
                end
                if (w_hdr_bad) begin
                    o_state.phase = fltp_pkg::PH_ERROR;
                    o_emit.emit   = 1'b1;
                    o_emit.status = fltp_pkg::ST_HEADER_BAD;
                end else if (i_state.pos >= 24'd12) begin
                    o_state.phase = fltp_pkg::PH_TAG_HDR;
                    o_state.pos   = 24'd0;
                    o_emit.emit   = 1'b1;
                    o_emit.status = fltp_pkg::ST_HEADER_OK;
                end else begin
                    o_state.pos = w_pos_inc;
                end
            end
            fltp_pkg::PH_TAG_HDR: begin
                if (i_state.pos == 24'd0) begin
                    o_state.hdr_byte = i_byte;
                    o_state.size     = 24'd0;
                    o_state.stamp    = 32'd0;
                    o_state.stream   = 24'd0;
                    o_state.media    = 8'd0;
                    o_state.packet   = 8'd0;
                    o_state.comp     = 24'd0;
                    o_state.cmd      = 8'd0;
                    o_state.extras   = 3'd0;
                end else if (i_state.pos <= 24'd3) begin
                    o_state.size = {i_state.size[15:0], i_byte};
                end else if (i_state.pos <= 24'd6) begin
                    o_state.stamp = {8'd0, i_state.stamp[15:0], i_byte};
                end else if (i_state.pos == 24'd7) begin
                    o_state.stamp[31:24] = i_byte;
                end else begin
                    o_state.stream = {i_state.stream[15:0], i_byte};
                end
                if (i_state.pos >= 24'd10) begin
                    o_state.pos   = 24'd0;
                    o_state.phase = (o_state.size != 24'd0) ? fltp_pkg::PH_PAYLOAD
                                                            : fltp_pkg::PH_TRAILER;
                end else begin
                    o_state.pos = w_pos_inc;
                end
            end
            fltp_pkg::PH_PAYLOAD: begin
                if (i_state.pos == 24'd0) begin
                    o_state.media = i_byte;
                end else if (i_state.hdr_byte[4:0] == fltp_pkg::TAG_AUDIO) begin
                    if (i_state.pos == 24'd1 && i_state.media[7:4] == fltp_pkg::CODEC_AAC) begin
                        o_state.packet    = i_byte;
                        o_state.extras[0] = 1'b1;
                    end
                end else if (i_state.hdr_byte[4:0] == fltp_pkg::TAG_VIDEO) begin
                    if (w_avc) begin
                        if (i_state.pos == 24'd1) begin
                            o_state.packet    = i_byte;
                            o_state.extras[0] = 1'b1;
                        end else if (i_state.pos >= 24'd2 && i_state.pos <= 24'd4) begin
                            o_state.comp = {i_state.comp[15:0], i_byte};
                            if (i_state.pos == 24'd4) begin
                                o_state.extras[1] = 1'b1;
                            end
                        end
                    end
                    if (!i_state.hdr_byte[5] && i_state.media[7:4] == fltp_pkg::FRAME_INFO
                            && i_state.pos == w_cmd_pos) begin
                        o_state.cmd       = i_byte;
                        o_state.extras[2] = 1'b1;
                    end
                end
                if (w_pos_inc >= i_state.size) begin
                    o_state.pos   = 24'd0;
                    o_state.phase = fltp_pkg::PH_TRAILER;
                end else begin
                    o_state.pos = w_pos_inc;
                end
            end
            fltp_pkg::PH_TRAILER: begin
                o_state.asm_word = w_asm_shift;
                if (i_state.pos >= 24'd3) begin
                    o_state.pos = 24'd0;
                    o_emit.emit = 1'b1;
                    if (w_asm_shift != {7'd0, w_trl_expect}) begin
                        o_state.phase = fltp_pkg::PH_ERROR;
                        o_emit.status = fltp_pkg::ST_TRAILER_BAD;
                    end else begin
                        o_state.phase = fltp_pkg::PH_TAG_HDR;
                    end
                end else begin
                    o_state.pos = w_pos_inc;
                end
            end
            default: begin
                o_state.phase = fltp_pkg::PH_ERROR;
            end
        endcase
    end

endmodule

/* rtl/flv_container_tag_parser_core.sv */
// flv_container_tag_parser_core: top level of the container tag parser.
// Depends on fltp_pkg and fltp_step.
//
// Takes a container stream one byte per slave transaction and sends one record
// per file header and per tag on the master side. A byte is registered on
// entry and processed from that register, and the record that it completes is
// registered in the output register. One byte is taken every clock; the only stall
// comes from a record still held in the output register while the byte now
// being processed completes another one. After an error record the parser
// stays silent until reset.
module flv_container_tag_parser_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // data_byte
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // frame_bits, filter_bit, tag_type, payload_size, time_stamp, stream_number,
    // media_byte, packet_kind, composition_offset, command_byte, extras_present
    output logic [fltp_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [1:0]                    o_m_tuser    // status
);

    fltp_pkg::t_state r_state;
    fltp_pkg::t_state n_state;
    fltp_pkg::t_emit  w_emit;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    logic [fltp_pkg::M_TDATA_W-1:0] r_out_data;
    logic [1:0]       r_out_user;
    logic             w_adv;
    logic             w_step;

    fltp_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_state (n_state),
        .o_emit  (w_emit)
    );

    assign w_adv      = !r_out_valid || i_m_tready || !w_emit.emit;
    assign w_step     = r_in_valid && w_adv;
    assign o_s_tready = !r_in_valid || w_adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= {fltp_pkg::PH_FILE_HDR,
                        {($bits(fltp_pkg::t_state) - $bits(fltp_pkg::t_phase)){1'b0}}};
        end else if (w_step) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_emit.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit.emit) begin
            r_out_user <= w_emit.status;
            r_out_data <= {5'd0, n_state.extras, n_state.cmd, n_state.comp, n_state.packet,
                           n_state.media, n_state.stream, n_state.stamp, n_state.size,
                           n_state.hdr_byte[4:0], n_state.hdr_byte[5], n_state.hdr_byte[7:6]};
        end
    end

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == fltp_pkg::PH_ERROR |=> r_state.phase == fltp_pkg::PH_ERROR)
        else $error("error phase left without reset");

    a_silent_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == fltp_pkg::PH_ERROR && !r_out_valid) |=> !r_out_valid)
        else $error("record issued after error");

    a_tag_hdr_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == fltp_pkg::PH_TAG_HDR |-> r_state.pos < 24'd11)
        else $error("tag header position out of range");

    a_trailer_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == fltp_pkg::PH_TRAILER |-> r_state.pos < 24'd4)
        else $error("trailer position out of range");

endmodule

/* tb/tb_flv_container_tag_parser_core.sv */
// tb_flv_container_tag_parser_core: self-checking bench for the container tag parser.
// Streams a container file through the slave port and checks each record against an
// in-bench parser. Depends on fltp_pkg and flv_container_tag_parser_core.
`timescale 1ns / 100ps

module tb_flv_container_tag_parser_core;

    localparam logic [4:0] TAG_SCRIPT = 5'd18;

    typedef enum int {
        HF_NONE,
        HF_SIGNATURE,
        HF_FLAGS,
        HF_OFFSET,
        HF_INIT_TRAILER
    } t_hdr_fault;

    typedef struct packed {
        fltp_pkg::t_status status;
        logic [1:0]  frame;
        logic        filt;
        logic [4:0]  ttype;
        logic [23:0] size;
        logic [31:0] stamp;
        logic [23:0] stream;
        logic [7:0]  media;
        logic [7:0]  packet;
        logic [23:0] comp;
        logic [7:0]  cmd;
        logic [2:0]  extras;
    } t_tag_rec;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata;   // data_byte
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    // frame_bits, filter_bit, tag_type, payload_size, time_stamp, stream_number,
    // media_byte, packet_kind, composition_offset, command_byte, extras_present
    logic [fltp_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic [1:0]             o_m_tuser;   // status

    flv_container_tag_parser_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // parser state mirrored in the bench
    fltp_pkg::t_phase ph = fltp_pkg::PH_FILE_HDR;
    logic [23:0] pos      = '0;
    logic [31:0] acc      = '0;
    logic [7:0]  hdr_byte = '0;
    logic [23:0] size_q   = '0;
    logic [31:0] stamp_q  = '0;
    logic [23:0] stream_q = '0;
    logic [7:0]  media_q  = '0;
    logic [7:0]  packet_q = '0;
    logic [23:0] comp_q   = '0;
    logic [7:0]  cmd_q    = '0;
    logic [2:0]  extras_q = '0;

    logic [7:0]  stream_bytes[$];
    t_tag_rec    pending_records[$];
    int          total_bytes;
    int          bytes_in      = 0;
    int          records_seen  = 0;
    int          mismatches    = 0;
    int          status_count[4];
    bit          byte_accepted = 1'b0;
    bit          hold_rx;
    t_hdr_fault  hdr_fault;

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor
    task automatic clear_tag_state();
        hdr_byte = '0;
        size_q   = '0;
        stamp_q  = '0;
        stream_q = '0;
        media_q  = '0;
        packet_q = '0;
        comp_q   = '0;
        cmd_q    = '0;
        extras_q = '0;
    endtask

    task automatic queue_record(input fltp_pkg::t_status st);
        t_tag_rec r;
        r.status = st;
        r.frame  = hdr_byte[7:6];
        r.filt   = hdr_byte[5];
        r.ttype  = hdr_byte[4:0];
        r.size   = size_q;
        r.stamp  = stamp_q;
        r.stream = stream_q;
        r.media  = media_q;
        r.packet = packet_q;
        r.comp   = comp_q;
        r.cmd    = cmd_q;
        r.extras = extras_q;
        pending_records.push_back(r);
    endtask

    task automatic capture_payload(input logic [23:0] p, input logic [7:0] b);
        logic avc;
        avc = (media_q[3:0] == fltp_pkg::CODEC_AVC);
        if (p == 0) begin
            media_q = b;
        end else if (hdr_byte[4:0] == fltp_pkg::TAG_AUDIO) begin
            if (p == 1 && media_q[7:4] == fltp_pkg::CODEC_AAC) begin
                packet_q    = b;
                extras_q[0] = 1'b1;
            end
        end else if (hdr_byte[4:0] == fltp_pkg::TAG_VIDEO) begin
            if (avc && p == 1) begin
                packet_q    = b;
                extras_q[0] = 1'b1;
            end else if (avc && p >= 2 && p <= 4) begin
                comp_q = {comp_q[15:0], b};
                if (p == 4)
                    extras_q[1] = 1'b1;
            end
            if (!hdr_byte[5] && media_q[7:4] == fltp_pkg::FRAME_INFO
                    && p == (avc ? 24'd5 : 24'd1)) begin
                cmd_q       = b;
                extras_q[2] = 1'b1;
            end
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [23:0] p;
        logic [23:0] nxt;
        p = pos;
        case (ph)
            fltp_pkg::PH_FILE_HDR: begin
                acc = {acc[23:0], b};
                if (p == 4)
                    media_q = b;
                if ((p == 3 && acc != fltp_pkg::FILE_SIGNATURE) ||
                    (p == 4 && (b & fltp_pkg::FLAG_RSVD_MASK) != 0) ||
                    (p == 8 && acc != fltp_pkg::FILE_DATA_OFFS) ||
                    (p >= 12 && acc != 0)) begin
                    ph = fltp_pkg::PH_ERROR;
                    queue_record(fltp_pkg::ST_HEADER_BAD);
                end else if (p >= 12) begin
                    queue_record(fltp_pkg::ST_HEADER_OK);
                    ph  = fltp_pkg::PH_TAG_HDR;
                    pos = '0;
                end else begin
                    pos = p + 24'd1;
                end
            end
            fltp_pkg::PH_TAG_HDR: begin
                if (p == 0) begin
                    clear_tag_state();
                    hdr_byte = b;
                end else if (p <= 3) begin
                    size_q = {size_q[15:0], b};
                end else if (p <= 6) begin
                    stamp_q = {8'h00, stamp_q[15:0], b};
                end else if (p == 7) begin
                    stamp_q[31:24] = b;
                end else begin
                    stream_q = {stream_q[15:0], b};
                end
                if (p + 1 >= 11) begin
                    pos = '0;
                    ph  = (size_q != 0) ? fltp_pkg::PH_PAYLOAD : fltp_pkg::PH_TRAILER;
                end else begin
                    pos = p + 24'd1;
                end
            end
            fltp_pkg::PH_PAYLOAD: begin
                capture_payload(p, b);
                nxt = p + 24'd1;
                if (nxt >= size_q) begin
                    pos = '0;
                    ph  = fltp_pkg::PH_TRAILER;
                end else begin
                    pos = nxt;
                end
            end
            fltp_pkg::PH_TRAILER: begin
                acc = {acc[23:0], b};
                if (p >= 3) begin
                    pos = '0;
                    if (acc != {8'h00, size_q} + 32'(fltp_pkg::TAG_HDR_LEN)) begin
                        ph = fltp_pkg::PH_ERROR;
                        queue_record(fltp_pkg::ST_TRAILER_BAD);
                    end else begin
                        ph = fltp_pkg::PH_TAG_HDR;
                        queue_record(fltp_pkg::ST_TAG);
                    end
                end else begin
                    pos = p + 24'd1;
                end
            end
            default: ph = fltp_pkg::PH_ERROR;
        endcase
    endtask

    // ---------------------------------------------------------------- stimulus
    task automatic push_be(input logic [31:0] v, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            stream_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic add_file_header(input t_hdr_fault hf);
        logic [31:0] sig;
        logic [7:0]  flags;
        logic [7:0]  rb;
        logic [31:0] offs;
        logic [31:0] itrl;
        sig   = fltp_pkg::FILE_SIGNATURE;
        flags = 8'h05;
        offs  = fltp_pkg::FILE_DATA_OFFS;
        itrl  = '0;
        case (hf)
            HF_SIGNATURE: sig = sig ^ (32'h1 << $urandom_range(0, 31));
            HF_FLAGS: begin
                do
                    rb = 8'h01 << $urandom_range(0, 7);
                while ((rb & fltp_pkg::FLAG_RSVD_MASK) == 0);
                flags = flags | rb;
            end
            HF_OFFSET: offs = offs ^ (32'h1 << $urandom_range(0, 31));
            HF_INIT_TRAILER: itrl = 32'h1 << $urandom_range(0, 31);
            default: ;
        endcase
        push_be(sig, 4);
        stream_bytes.push_back(flags);
        push_be(offs, 4);
        push_be(itrl, 4);
    endtask

    task automatic add_tag(input logic [7:0] hdr, input int sz, input logic [7:0] lead,
                           input logic [31:0] stamp, input logic [23:0] sid,
                           input bit bad_trailer);
        logic [31:0] trl;
        stream_bytes.push_back(hdr);
        push_be(32'(sz), 3);
        push_be(stamp, 3);
        stream_bytes.push_back(stamp[31:24]);
        push_be({8'h00, sid}, 3);
        for (int i = 0; i < sz; i++)
            stream_bytes.push_back(i == 0 ? lead : 8'($urandom));
        trl = 32'(sz) + 32'(fltp_pkg::TAG_HDR_LEN);
        if (bad_trailer)
            trl = trl ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
        push_be(trl, 4);
    endtask

    task automatic add_random_tag(input bit bad_trailer);
        logic [7:0] hdr;
        logic [7:0] lead;
        int         kind;
        int         sz;
        kind = $urandom_range(0, 5);
        hdr  = 8'($urandom);
        lead = 8'($urandom);
        case (kind)
            0, 5: begin
                hdr[4:0] = fltp_pkg::TAG_AUDIO;
                if ($urandom_range(0, 2) != 0)
                    lead[7:4] = fltp_pkg::CODEC_AAC;
            end
            1, 2: begin
                hdr[4:0] = fltp_pkg::TAG_VIDEO;
                if ($urandom_range(0, 3) != 0)
                    hdr[5] = 1'b0;
                if ($urandom_range(0, 2) != 0)
                    lead[3:0] = fltp_pkg::CODEC_AVC;
                if ($urandom_range(0, 1) != 0)
                    lead[7:4] = fltp_pkg::FRAME_INFO;
            end
            3: hdr[4:0] = TAG_SCRIPT;
            default: ;
        endcase
        sz = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 60) : $urandom_range(0, 8);
        add_tag(hdr, sz, lead, $urandom, 24'($urandom), bad_trailer);
    endtask

    function automatic int sender_idle_pct();
        if (bytes_in < total_bytes / 3)
            return 7;
        if (bytes_in < 2 * total_bytes / 3)
            return 47;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (bytes_in < total_bytes / 3)
            return 47;
        if (bytes_in < 2 * total_bytes / 3)
            return 7;
        return 0;
    endfunction

    // ---------------------------------------------------------------- driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_m_tready <= 1'b0;
        end else begin
            if (!i_s_tvalid || byte_accepted) begin
                if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= stream_bytes.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= !hold_rx && ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // ---------------------------------------------------------------- monitor
    task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, e, a);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tag_rec e;
        byte_accepted = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                parse_byte(i_s_tdata);
                bytes_in++;
                byte_accepted = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                records_seen++;
                if (pending_records.size() == 0) begin
                    $display("%0t: unexpected record, expected none actual status %0h",
                             $time, o_m_tuser);
                    mismatches++;
                end else begin
                    e = pending_records.pop_front();
                    status_count[e.status]++;
                    check_field("status", 32'(e.status), 32'(o_m_tuser));
                    check_field("frame_bits", 32'(e.frame), 32'(o_m_tdata[1:0]));
                    check_field("filter_bit", 32'(e.filt), 32'(o_m_tdata[2]));
                    check_field("tag_type", 32'(e.ttype), 32'(o_m_tdata[7:3]));
                    check_field("payload_size", 32'(e.size), 32'(o_m_tdata[31:8]));
                    check_field("time_stamp", e.stamp, o_m_tdata[63:32]);
                    check_field("stream_number", 32'(e.stream), 32'(o_m_tdata[87:64]));
                    check_field("media_byte", 32'(e.media), 32'(o_m_tdata[95:88]));
                    check_field("packet_kind", 32'(e.packet), 32'(o_m_tdata[103:96]));
                    check_field("composition_offset", 32'(e.comp),
                                32'(o_m_tdata[127:104]));
                    check_field("command_byte", 32'(e.cmd), 32'(o_m_tdata[135:128]));
                    check_field("extras_present", 32'(e.extras), 32'(o_m_tdata[138:136]));
                end
            end
        end
    end

    // long receiver stall so the output register backs up into the input
    initial begin
        hold_rx = 1'b0;
        wait (bytes_in >= 300);
        hold_rx = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    initial begin
        #200000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        int r;
        i_rst_n = 1'b0;

        // a quarter of runs open with a broken file header; the rest is then ignored
        r = $urandom_range(0, 15);
        hdr_fault = (r >= 1 && r <= 4) ? t_hdr_fault'(r) : HF_NONE;
        add_file_header(hdr_fault);
        // zero-size tag with every other header field at its top value
        add_tag(8'hFF, 0, 8'h00, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0);
        while (stream_bytes.size() < 1500)
            add_random_tag(1'b0);
        add_random_tag(1'b1);
        repeat (20)
            stream_bytes.push_back(8'($urandom));
        total_bytes = stream_bytes.size();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stream_bytes.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (pending_records.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Streamed %0d bytes with a %s file header under mixed stalls, %0d records",
                 bytes_in, hdr_fault.name(), records_seen);
        $display("Records: %0d tag, %0d header ok, %0d bad header, %0d bad trailer; %0d mismatches",
                 status_count[fltp_pkg::ST_TAG], status_count[fltp_pkg::ST_HEADER_OK],
                 status_count[fltp_pkg::ST_HEADER_BAD], status_count[fltp_pkg::ST_TRAILER_BAD],
                 mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
